FILE: src/sces_pkg.sv
// Shared types and constants for the sound channel envelope/sweep core.
// No dependencies; used by the interfaces and every module of the block.
package sces_pkg;

   // Default channel count and the most channels a tick reports
   localparam int CHANNELS_DEF = 4;
   localparam int MAX_REPORT   = 4;

   // Field widths
   localparam int CH_W    = 2;
   localparam int GAIN_W  = 16;
   localparam int FREQ_W  = 24;
   localparam int FACT_W  = 16;
   localparam int TICKS_W = 16;

   localparam logic [FREQ_W-1:0]  FREQ_MAX     = 24'hFF_FFFF;
   localparam logic [FACT_W-1:0]  SWEEP_ONE    = 16'h4000;
   localparam logic [TICKS_W-1:0] ELAPSED_MAX  = 16'hFFFF;

   // Request codes
   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_PLAY = 2'd1,
      REQ_STOP = 2'd2
   } req_kind_type;

   // One channel's stored state
   typedef struct packed {
      logic [GAIN_W-1:0]  gain_level;
      logic [FREQ_W-1:0]  freq_level;
      logic [TICKS_W-1:0] elapsed_ticks;
      logic               play_flag;
      logic [FACT_W-1:0]  decay_store;
      logic [FACT_W-1:0]  sweep_store;
      logic [FREQ_W-1:0]  end_store;
      logic [TICKS_W-1:0] length_store;
   } entry_type;

   // Tick update of one channel
   typedef struct packed {
      entry_type entry;
      logic      stopped;
   } tick_out_type;

   // One result item
   typedef struct packed {
      logic [CH_W-1:0]   out_channel;
      logic [GAIN_W-1:0] gain_now;
      logic [FREQ_W-1:0] freq_now;
      logic              playing;
      logic              stopped_now;
      logic              last;
   } rsp_type;

endpackage

FILE: src/sces_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on sces_pkg for field widths.
interface sces_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic [sces_pkg::CH_W-1:0]        channel;
   logic [sces_pkg::GAIN_W-1:0]      start_gain;
   logic [sces_pkg::FREQ_W-1:0]      start_freq;
   logic [sces_pkg::FACT_W-1:0]      decay_factor;
   logic [sces_pkg::FACT_W-1:0]      sweep_factor;
   logic [sces_pkg::FREQ_W-1:0]      end_freq;
   logic [sces_pkg::TICKS_W-1:0]     length_ticks;

   modport source (
      output valid, req_type, channel, start_gain, start_freq,
             decay_factor, sweep_factor, end_freq, length_ticks,
      input  ready
   );
   modport sink (
      input  valid, req_type, channel, start_gain, start_freq,
             decay_factor, sweep_factor, end_freq, length_ticks,
      output ready
   );
endinterface

interface sces_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sces_pkg::CH_W-1:0]      out_channel;
   logic [sces_pkg::GAIN_W-1:0]    gain_now;
   logic [sces_pkg::FREQ_W-1:0]    freq_now;
   logic                           playing;
   logic                           stopped_now;
   logic                           last;

   modport source (
      output valid, out_channel, gain_now, freq_now, playing, stopped_now, last,
      input  ready
   );
   modport sink (
      input  valid, out_channel, gain_now, freq_now, playing, stopped_now, last,
      output ready
   );
endinterface

FILE: src/sces_state_mem.sv
// Channel state memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on sces_pkg.
module sces_state_mem #(
   parameter int CHANNELS = sces_pkg::CHANNELS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           wr_en,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
   input  sces_pkg::entry_type                            wr_data,
   input  logic                                           rd_en,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
   output sces_pkg::entry_type                            rd_data
);

   sces_pkg::entry_type mem_ff [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   sces_pkg::entry_type rd_data_ff;
   logic                rd_valid_ff;

   // Storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: src/sces_tick_unit.sv
// Per-channel tick update: elapsed count and length stop, then registered
// gain and frequency products, then saturation and sweep end check.
// Depends on sces_pkg.
module sces_tick_unit (
   input  logic                   clock,
   input  logic                   load,
   input  sces_pkg::entry_type    cur,
   output sces_pkg::tick_out_type res
);

   localparam int GPROD_W = 2 * sces_pkg::GAIN_W;
   localparam int FPROD_W = sces_pkg::FREQ_W + sces_pkg::FACT_W;
   localparam int SWEEP_FRAC = 14;
   localparam int FSHIFT_W = FPROD_W - SWEEP_FRAC;

   logic [sces_pkg::TICKS_W-1:0] elapsed_in;
   logic                         len_stop;
   logic [GPROD_W-1:0]           gain_prod_in;
   logic [FPROD_W-1:0]           freq_prod_in;

   sces_pkg::entry_type          ent_ff;
   logic [sces_pkg::TICKS_W-1:0] elapsed_ff;
   logic                         play_ff;
   logic [GPROD_W-1:0]           gain_prod_ff;
   logic [FPROD_W-1:0]           freq_prod_ff;

   logic [FSHIFT_W-1:0]          freq_sh;
   logic [sces_pkg::FREQ_W-1:0]  freq_sat;
   logic                         sweep_on;
   logic                         end_hit;
   logic                         play_new;

   // First half: count, length check, products
   always_comb begin
      elapsed_in = (cur.elapsed_ticks != sces_pkg::ELAPSED_MAX) ?
                   cur.elapsed_ticks + 1'b1 : cur.elapsed_ticks;
      len_stop   = (cur.length_store != '0) && (elapsed_in >= cur.length_store);
      gain_prod_in = GPROD_W'(cur.gain_level) * GPROD_W'(cur.decay_store);
      freq_prod_in = FPROD_W'(cur.freq_level) * FPROD_W'(cur.sweep_store);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff       <= cur;
         elapsed_ff   <= elapsed_in;
         play_ff      <= cur.play_flag && !len_stop;
         gain_prod_ff <= gain_prod_in;
         freq_prod_ff <= freq_prod_in;
      end
   end

   // Second half: scale back, saturate, end-of-sweep stop
   always_comb begin
      freq_sh  = freq_prod_ff[FPROD_W-1:SWEEP_FRAC];
      freq_sat = (|freq_sh[FSHIFT_W-1:sces_pkg::FREQ_W]) ? sces_pkg::FREQ_MAX :
                 freq_sh[sces_pkg::FREQ_W-1:0];
      sweep_on = (ent_ff.sweep_store != '0);
      end_hit  = sweep_on && (ent_ff.end_store != '0) &&
                 (((ent_ff.sweep_store > sces_pkg::SWEEP_ONE) && (freq_sat >= ent_ff.end_store)) ||
                  ((ent_ff.sweep_store < sces_pkg::SWEEP_ONE) && (freq_sat <= ent_ff.end_store)));
      play_new = play_ff && !end_hit;

      res                     = '0;
      res.entry               = ent_ff;
      res.entry.elapsed_ticks = elapsed_ff;
      res.entry.play_flag     = play_new;
      res.entry.gain_level    = (ent_ff.decay_store != '0) ?
                                gain_prod_ff[GPROD_W-1:sces_pkg::GAIN_W] : ent_ff.gain_level;
      res.entry.freq_level    = sweep_on ? freq_sat : ent_ff.freq_level;
      res.stopped             = ent_ff.play_flag && !play_new;
   end

endmodule

FILE: src/sound_channel_envelope_sweep_core.sv
// Sound channel envelope/sweep core: top level with request sequencer.
// Depends on sces_pkg, sces_if, sces_state_mem and sces_tick_unit.
//
// All channel state sits in one memory with a single read-modify-write path,
// so the block works on one item at a time. After a tick is accepted, each
// channel in turn is read, multiplied and written back in a read, a multiply
// and a write-back state, set by the memory read register and the register
// after the gain and frequency multipliers. A play is written after accept;
// a stop is read, then written back. Results go out through an output
// register, so a new item can be accepted while the last result still waits;
// a result that is not taken stalls the next channel's write-back. Each entry
// is written back before any later read of it is issued, so no forwarding is
// needed. Reset clears the valid bits at once; there is no clearing pass.
module sound_channel_envelope_sweep_core #(
   parameter int CHANNELS = sces_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sces_req_if.sink    req_bus,
   sces_rsp_if.source  rsp_bus
);

   localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int REPORT = (CHANNELS < sces_pkg::MAX_REPORT) ? CHANNELS :
                           sces_pkg::MAX_REPORT;
   localparam logic [AW-1:0] LAST_CH  = AW'(CHANNELS - 1);
   localparam logic [AW:0]   REPORT_N = (AW+1)'(REPORT);
   localparam int CMP_W = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_MUL,
      ST_TICK_WB,
      ST_PLAY_WR,
      ST_STOP_RD,
      ST_STOP_WB,
      ST_REJECT
   } state_type;

   state_type                      state_ff;
   logic [AW-1:0]                  cnt_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_emit;
   sces_pkg::rsp_type              rsp_ff;

   // Latched request payload
   logic [sces_pkg::CH_W-1:0]      chan_ff;
   logic [sces_pkg::GAIN_W-1:0]    gain_ff;
   logic [sces_pkg::FREQ_W-1:0]    freq_ff;
   logic [sces_pkg::FACT_W-1:0]    decay_ff;
   logic [sces_pkg::FACT_W-1:0]    sweep_ff;
   logic [sces_pkg::FREQ_W-1:0]    end_ff;
   logic [sces_pkg::TICKS_W-1:0]   length_ff;

   logic                           can_emit;
   logic                           reported;
   logic                           last_report;
   logic                           chan_ok;
   logic [AW-1:0]                  chan_addr;
   logic                           mem_rd_en;
   logic [AW-1:0]                  mem_rd_addr;
   logic                           mem_wr_en;
   logic [AW-1:0]                  mem_wr_addr;
   sces_pkg::entry_type            mem_wr_data;
   sces_pkg::entry_type            mem_rd_data;
   logic                           tu_load;
   sces_pkg::tick_out_type         tu_res;

   sces_state_mem #(
      .CHANNELS (CHANNELS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sces_tick_unit u_tick (
      .clock (clock),
      .load  (tu_load),
      .cur   (mem_rd_data),
      .res   (tu_res)
   );

   // Handshake and addressing
   assign can_emit    = !rsp_valid_ff || rsp_bus.ready;
   assign reported    = ({1'b0, cnt_ff} < REPORT_N);
   assign last_report = ({1'b0, cnt_ff} == (REPORT_N - 1'b1));
   assign chan_ok     = (CMP_W'(req_bus.channel) < CMP_W'(CHANNELS));
   assign chan_addr   = AW'(chan_ff);
   assign tu_load     = (state_ff == ST_TICK_MUL);
   assign mem_rd_en   = (state_ff == ST_TICK_RD) || (state_ff == ST_STOP_RD);
   assign mem_rd_addr = (state_ff == ST_TICK_RD) ? cnt_ff : chan_addr;
   assign mem_wr_addr = (state_ff == ST_TICK_WB) ? cnt_ff : chan_addr;

   // Output valid: set when a result is loaded, cleared when it is taken
   assign rsp_emit     = can_emit &&
                         (((state_ff == ST_TICK_WB) && reported) ||
                          (state_ff == ST_PLAY_WR) || (state_ff == ST_STOP_WB) ||
                          (state_ff == ST_REJECT));
   assign rsp_valid_in = rsp_emit || (rsp_valid_ff && !rsp_bus.ready);

   // Write-back data and enable
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_data = '0;
      unique case (state_ff)
         ST_TICK_WB: begin
            mem_wr_en   = can_emit || !reported;
            mem_wr_data = tu_res.entry;
         end
         ST_PLAY_WR: begin
            mem_wr_en                 = can_emit;
            mem_wr_data.gain_level    = gain_ff;
            mem_wr_data.freq_level    = freq_ff;
            mem_wr_data.elapsed_ticks = '0;
            mem_wr_data.play_flag     = 1'b1;
            mem_wr_data.decay_store   = decay_ff;
            mem_wr_data.sweep_store   = sweep_ff;
            mem_wr_data.end_store     = end_ff;
            mem_wr_data.length_store  = length_ff;
         end
         ST_STOP_WB: begin
            mem_wr_en             = can_emit;
            mem_wr_data           = mem_rd_data;
            mem_wr_data.play_flag = 1'b0;
         end
         default: begin
            mem_wr_en   = 1'b0;
            mem_wr_data = '0;
         end
      endcase
   end

   // Sequencer, request latch and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  chan_ff   <= req_bus.channel;
                  gain_ff   <= req_bus.start_gain;
                  freq_ff   <= req_bus.start_freq;
                  decay_ff  <= req_bus.decay_factor;
                  sweep_ff  <= req_bus.sweep_factor;
                  end_ff    <= req_bus.end_freq;
                  length_ff <= req_bus.length_ticks;
                  unique case (req_bus.req_type)
                     sces_pkg::REQ_TICK: begin
                        cnt_ff   <= '0;
                        state_ff <= ST_TICK_RD;
                     end
                     sces_pkg::REQ_PLAY: state_ff <= chan_ok ? ST_PLAY_WR : ST_REJECT;
                     sces_pkg::REQ_STOP: state_ff <= chan_ok ? ST_STOP_RD : ST_REJECT;
                     default:            state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_TICK_RD:  state_ff <= ST_TICK_MUL;
            ST_TICK_MUL: state_ff <= ST_TICK_WB;
            ST_TICK_WB: begin
               if (can_emit || !reported) begin
                  if (reported) begin
                     rsp_ff.out_channel <= sces_pkg::CH_W'(cnt_ff);
                     rsp_ff.gain_now    <= tu_res.entry.gain_level;
                     rsp_ff.freq_now    <= tu_res.entry.freq_level;
                     rsp_ff.playing     <= tu_res.entry.play_flag;
                     rsp_ff.stopped_now <= tu_res.stopped;
                     rsp_ff.last        <= last_report;
                  end
                  if (cnt_ff == LAST_CH) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= ST_TICK_RD;
                  end
               end
            end
            ST_PLAY_WR: begin
               if (can_emit) begin
                  rsp_ff.out_channel <= chan_ff;
                  rsp_ff.gain_now    <= gain_ff;
                  rsp_ff.freq_now    <= freq_ff;
                  rsp_ff.playing     <= 1'b1;
                  rsp_ff.stopped_now <= 1'b0;
                  rsp_ff.last        <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end
            ST_STOP_RD: state_ff <= ST_STOP_WB;
            ST_STOP_WB: begin
               if (can_emit) begin
                  rsp_ff.out_channel <= chan_ff;
                  rsp_ff.gain_now    <= mem_rd_data.gain_level;
                  rsp_ff.freq_now    <= mem_rd_data.freq_level;
                  rsp_ff.playing     <= 1'b0;
                  rsp_ff.stopped_now <= 1'b0;
                  rsp_ff.last        <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end
            ST_REJECT: begin
               // channel beyond the configured count: zero result, no write
               if (can_emit) begin
                  rsp_ff.out_channel <= chan_ff;
                  rsp_ff.gain_now    <= '0;
                  rsp_ff.freq_now    <= '0;
                  rsp_ff.playing     <= 1'b0;
                  rsp_ff.stopped_now <= 1'b0;
                  rsp_ff.last        <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Port drive
   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_ff.out_channel;
   assign rsp_bus.gain_now    = rsp_ff.gain_now;
   assign rsp_bus.freq_now    = rsp_ff.freq_now;
   assign rsp_bus.playing     = rsp_ff.playing;
   assign rsp_bus.stopped_now = rsp_ff.stopped_now;
   assign rsp_bus.last        = rsp_ff.last;

   // Separate read and write ports, but a read and a write never share a cycle
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("state memory read and write in the same cycle");

   // Tick unit only loads data from a read issued the cycle before
   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      tu_load |-> $past(mem_rd_en))
      else $error("tick unit loaded without a preceding memory read");

   // A channel reported as stopped this tick cannot still be playing
   a_stop_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.stopped_now) |-> !rsp_ff.playing)
      else $error("result flags stopped and playing together");

   // Reset leaves the sequencer idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> ((state_ff == ST_IDLE) && !rsp_valid_ff))
      else $error("sequencer not idle after reset");

endmodule
